// ===== sv/eed_pkg.sv =====
// ----------------------------------------------------------------------------
// eed_pkg: shared types and constants of the echo escape decoder
// Decode modes, state and result records, byte codes and the escape table.
// ----------------------------------------------------------------------------
package eed_pkg;

    // byte codes
    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_C    = 8'h63;
    // upper five bits shared by the octal digits '0'..'7'
    localparam logic [4:0] OCT_HIGH  = 5'b00110;
    localparam logic [2:0] OCT_MAX   = 3'd3;
    localparam int         MAX_RES   = 2;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_OCT   = 2'd2,
        MODE_SPARE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] oval;
        logic [1:0] ocnt;
        logic       halt;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       halted;
        logic       last;
    } t_result;

    // escape letter -> control byte; bit 8 set when the letter is known
    function automatic logic [8:0] esc_code(input logic [7:0] b);
        logic [8:0] code;
        unique case (b)
            8'h45:     code = {1'b1, ESC_BYTE};   // E
            8'h61:     code = {1'b1, 8'h07};      // a
            8'h62:     code = {1'b1, 8'h08};      // b
            8'h66:     code = {1'b1, 8'h0C};      // f
            8'h6E:     code = {1'b1, 8'h0A};      // n
            8'h72:     code = {1'b1, 8'h0D};      // r
            8'h76:     code = {1'b1, 8'h0B};      // v
            8'h74:     code = {1'b1, 8'h09};      // t
            BACKSLASH: code = {1'b1, BACKSLASH};
            default:   code = 9'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/eed_decode.sv =====
// ----------------------------------------------------------------------------
// eed_decode: per-word escape decode
// Takes the current decode state and one input word, returns the next state
// and zero, one or two result words.
// ----------------------------------------------------------------------------
module eed_decode
    import eed_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_arg_end,
    input  logic       i_new_cmd,
    input  logic       i_pass,
    output t_state     o_state,
    output logic [1:0] o_count,
    output t_result    o_res [MAX_RES]
);

    t_state     st;
    logic [1:0] k;
    logic [2:0] cnt3;
    logic [8:0] code;
    logic [7:0] rb [MAX_RES];
    logic       rv [MAX_RES];

    always_comb begin
        st   = i_state;
        k    = 2'd0;
        cnt3 = 3'd0;
        code = esc_code(i_byte);
        for (int i = 0; i < MAX_RES; i++) begin
            rb[i] = 8'd0;
            rv[i] = 1'b0;
        end

        // a new command drops the halt and any pending escape
        if (i_new_cmd) begin
            st = '{mode: MODE_TEXT, oval: 8'd0, ocnt: 2'd0, halt: 1'b0};
        end

        if (st.halt) begin
            st.mode = MODE_TEXT; st.oval = 8'd0; st.ocnt = 2'd0;
            k = 2'd1;
        end else if (i_pass) begin
            st.mode = MODE_TEXT; st.oval = 8'd0; st.ocnt = 2'd0;
            rb[0] = i_byte; rv[0] = 1'b1; k = 2'd1;
        end else begin
            unique case (st.mode)
                MODE_ESC: begin
                    st.mode = MODE_TEXT;
                    if (code[8]) begin
                        rb[0] = code[7:0]; rv[0] = 1'b1; k = 2'd1;
                    end else if (i_byte == CHAR_C) begin
                        st.halt = 1'b1;
                        k = 2'd1;
                    end else if (i_byte == CHAR_ZERO) begin
                        st.mode = MODE_OCT; st.oval = 8'd0; st.ocnt = 2'd0;
                    end else begin
                        // unknown escape: backslash, then the byte as text
                        rb[0] = BACKSLASH; rv[0] = 1'b1;
                        rb[1] = i_byte;    rv[1] = 1'b1;
                        k = 2'd2;
                    end
                end
                MODE_OCT: begin
                    if (i_byte[7:3] == OCT_HIGH) begin
                        st.oval = {st.oval[4:0], i_byte[2:0]};
                        cnt3    = {1'b0, st.ocnt} + 3'd1;
                        if (cnt3 >= OCT_MAX) begin
                            rb[0] = st.oval; rv[0] = 1'b1; k = 2'd1;
                            st.mode = MODE_TEXT; st.oval = 8'd0; st.ocnt = 2'd0;
                        end else begin
                            st.ocnt = cnt3[1:0];
                        end
                    end else begin
                        // non-digit ends the number, then is decoded as in text mode
                        rb[0] = st.oval; rv[0] = 1'b1; k = 2'd1;
                        st.oval = 8'd0; st.ocnt = 2'd0;
                        if (i_byte == BACKSLASH) begin
                            st.mode = MODE_ESC;
                        end else begin
                            st.mode = MODE_TEXT;
                            rb[1] = i_byte; rv[1] = 1'b1; k = 2'd2;
                        end
                    end
                end
                default: begin
                    if (i_byte == BACKSLASH) begin
                        st.mode = MODE_ESC;
                    end else begin
                        st.mode = MODE_TEXT;
                        rb[0] = i_byte; rv[0] = 1'b1; k = 2'd1;
                    end
                end
            endcase

            // flush a pending escape at the end of an argument
            if (i_arg_end && !st.halt) begin
                if (st.mode == MODE_ESC) begin
                    rb[k[0]] = BACKSLASH; rv[k[0]] = 1'b1; k = k + 2'd1;
                end else if (st.mode == MODE_OCT) begin
                    rb[k[0]] = st.oval;   rv[k[0]] = 1'b1; k = k + 2'd1;
                end
            end
            if (i_arg_end) begin
                st.mode = MODE_TEXT; st.oval = 8'd0; st.ocnt = 2'd0;
            end
        end
    end

    always_comb begin
        o_state = st;
        o_count = k;
        for (int i = 0; i < MAX_RES; i++) begin
            o_res[i].data   = rb[i];
            o_res[i].vld    = rv[i];
            o_res[i].halted = st.halt;
        end
        o_res[0].last = (k == 2'd1);
        o_res[1].last = 1'b1;
    end

endmodule

// ===== sv/echo_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// echo_escape_decoder: backslash escape decoder for echo argument bytes
// One word in per cycle while the m side keeps up; decoded words queue in a two-entry output buffer.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata         | tlast       | tuser
// s       | in  | in_byte       | arg_end     | new_command
// m       | out | out_byte      | last_of_run | [0] out_valid, [1] halted
// cfg     | in  | pass_through (i_cfg_wdata, written when i_cfg_we is high)
//
// An input word is decoded in the cycle it is accepted; its results appear on
// the m side at the next clock edge. One word per cycle is sustained while
// each word gives at most one result and the m side is ready; a word giving
// two results holds o_s_tready low while the second drains from the two-entry
// output buffer. Reset (synchronous, active low) clears the decode state, the
// halt flag, pass_through and the buffer.
// ----------------------------------------------------------------------------
module echo_escape_decoder
    import eed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    input  logic       i_s_tuser,   // [0] new_command
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,
    output logic [1:0] o_m_tuser    // [0] out_valid, [1] halted
);

    logic       r_pass;
    t_state     r_state, n_state;
    t_result    r_q0, r_q1, n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] dec_cnt;
    t_result    dec_res [MAX_RES];
    logic       accept, pop;

    // decode logic
    eed_decode u_decode (
        .i_state   (r_state),
        .i_byte    (i_s_tdata),
        .i_arg_end (i_s_tlast),
        .i_new_cmd (i_s_tuser),
        .i_pass    (r_pass),
        .o_state   (n_state),
        .o_count   (dec_cnt),
        .o_res     (dec_res)
    );

    // handshakes: take a word only when the buffer is empty after this cycle
    assign pop        = (r_cnt != 2'd0) && i_m_tready;
    assign o_s_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    // output buffer next value
    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        if (accept) begin
            n_cnt = dec_cnt;
            n_q0  = dec_res[0];
            n_q1  = dec_res[1];
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
            n_q0  = r_q1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass  <= 1'b0;
            r_state <= '{mode: MODE_TEXT, oval: 8'd0, ocnt: 2'd0, halt: 1'b0};
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_pass <= i_cfg_wdata;
            end
            if (accept) begin
                r_state <= n_state;
            end
            r_cnt <= n_cnt;
        end
    end

    // buffer payload
    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_q0.data;
    assign o_m_tlast  = r_q0.last;
    assign o_m_tuser  = {r_q0.halted, r_q0.vld};

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output buffer count out of range");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_cnt == 2'd0 || pop)) else $error("word taken into full buffer");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_q0.last && r_q1.last))
        else $error("first of a result pair marked last");

    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halt |-> (r_state.mode == MODE_TEXT && r_state.ocnt == 2'd0))
        else $error("escape pending while halted");

    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ocnt != 2'd3) else $error("octal digit count overflow");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the echo escape decoder
// Streams argument bytes into the decoder and checks every output word against
// a cycle-free decode model kept in the bench. Covers all escapes, octal
// sequences, the halt escape, new commands, argument ends and raw mode, under
// random idle patterns on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_top;
    import eed_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       eoa;
        logic       ncmd;
    } t_word;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = 8'h00;   // [7:0] in_byte
    logic       i_s_tlast   = 1'b0;
    logic       i_s_tuser   = 1'b0;    // [0] new_command
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;             // [7:0] out_byte
    logic       o_m_tlast;
    logic [1:0] o_m_tuser;             // [0] out_valid, [1] halted

    echo_escape_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // stimulus and expected output words
    t_word   arg_bytes [$];
    t_result pending_out [$];
    t_word   drv_word;

    // decode model state
    logic       raw_mode = 1'b0;
    t_mode      dec_mode = MODE_TEXT;
    logic [7:0] oct_val  = 8'h00;
    logic [1:0] oct_cnt  = 2'd0;
    logic       halt_on  = 1'b0;

    // words produced by the current input word
    logic [7:0] step_data [MAX_RES];
    logic       step_vld  [MAX_RES];
    int         step_n;

    int src_idle   = 0;
    int sink_idle  = 0;
    int halt_left  = 0;
    int gen_count  = 0;
    int err_count  = 0;
    int n_in       = 0;
    int n_out      = 0;
    int n_status   = 0;
    int n_raw      = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---- decode model ----
    function automatic void emit(input logic [7:0] d, input logic v);
        step_data[step_n] = d;
        step_vld[step_n]  = v;
        step_n++;
    endfunction

    function automatic void clear_escape();
        dec_mode = MODE_TEXT;
        oct_val  = 8'h00;
        oct_cnt  = 2'd0;
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == BACKSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            dec_mode = MODE_TEXT;
            emit(b, 1'b1);
        end
    endfunction

    // control byte for a known escape letter; bit 8 marks a hit
    function automatic logic [8:0] ctrl_of(input logic [7:0] b);
        case (b)
            "E":       return {1'b1, ESC_BYTE};
            "a":       return {1'b1, 8'h07};
            "b":       return {1'b1, 8'h08};
            "f":       return {1'b1, 8'h0C};
            "n":       return {1'b1, 8'h0A};
            "r":       return {1'b1, 8'h0D};
            "v":       return {1'b1, 8'h0B};
            "t":       return {1'b1, 8'h09};
            BACKSLASH: return {1'b1, BACKSLASH};
            default:   return 9'd0;
        endcase
    endfunction

    function automatic void decode_word(input logic [7:0] b, input logic eoa,
                                        input logic ncmd);
        logic [8:0] code;
        t_result    r;
        step_n = 0;
        n_in++;
        if (ncmd) begin
            halt_on = 1'b0;
            clear_escape();
        end
        if (halt_on) begin
            clear_escape();
            emit(8'h00, 1'b0);
        end else if (raw_mode) begin
            clear_escape();
            emit(b, 1'b1);
            n_raw++;
        end else begin
            case (dec_mode)
                MODE_ESC: begin
                    code     = ctrl_of(b);
                    dec_mode = MODE_TEXT;
                    if (code[8]) begin
                        emit(code[7:0], 1'b1);
                    end else if (b == CHAR_C) begin
                        halt_on = 1'b1;
                        emit(8'h00, 1'b0);
                    end else if (b == CHAR_ZERO) begin
                        dec_mode = MODE_OCT;
                        oct_val  = 8'h00;
                        oct_cnt  = 2'd0;
                    end else begin
                        emit(BACKSLASH, 1'b1);
                        plain_byte(b);
                    end
                end
                MODE_OCT: begin
                    if (b[7:3] == OCT_HIGH) begin
                        oct_val = {oct_val[4:0], b[2:0]};
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == 2'd3) begin
                            emit(oct_val, 1'b1);
                            clear_escape();
                        end
                    end else begin
                        emit(oct_val, 1'b1);
                        oct_val = 8'h00;
                        oct_cnt = 2'd0;
                        plain_byte(b);
                    end
                end
                default: plain_byte(b);
            endcase
            // flush a pending escape at the end of an argument
            if (eoa && !halt_on) begin
                if (dec_mode == MODE_ESC)
                    emit(BACKSLASH, 1'b1);
                else if (dec_mode == MODE_OCT)
                    emit(oct_val, 1'b1);
            end
            if (eoa)
                clear_escape();
        end
        for (int i = 0; i < step_n; i++) begin
            r.data   = step_data[i];
            r.vld    = step_vld[i];
            r.halted = halt_on;
            r.last   = (i == step_n - 1);
            pending_out.push_back(r);
        end
    endfunction

    // ---- driver: one word per handshake, random gaps ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                decode_word(i_s_tdata, i_s_tlast, i_s_tuser);
            if (!i_s_tvalid || o_s_tready) begin
                if (arg_bytes.size() > 0 && $urandom_range(99) >= src_idle) begin
                    drv_word = arg_bytes.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= drv_word.b;
                    i_s_tlast  <= drv_word.eoa;
                    i_s_tuser  <= drv_word.ncmd;
                end else begin
                    // junk on the bus while idle
                    i_s_tvalid <= 1'b0;
                    i_s_tdata  <= 8'($urandom_range(255));
                    i_s_tlast  <= 1'($urandom_range(1));
                    i_s_tuser  <= 1'($urandom_range(1));
                end
            end
        end
    end

    // ---- monitor: compare each output word with the oldest expected one ----
    always @(posedge i_clk) begin
        t_result want;
        if (o_m_tvalid && i_m_tready) begin
            if (pending_out.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word byte=%02h vld=%b halted=%b last=%b",
                         $time, o_m_tdata, o_m_tuser[0], o_m_tuser[1], o_m_tlast);
            end else begin
                want = pending_out.pop_front();
                n_out++;
                if (!want.vld)
                    n_status++;
                if (o_m_tdata !== want.data || o_m_tuser[0] !== want.vld ||
                    o_m_tuser[1] !== want.halted || o_m_tlast !== want.last) begin
                    err_count++;
                    $display("%0t: mismatch exp byte=%02h vld=%b halted=%b last=%b",
                             $time, want.data, want.vld, want.halted, want.last);
                    $display("%0t:          got byte=%02h vld=%b halted=%b last=%b",
                             $time, o_m_tdata, o_m_tuser[0], o_m_tuser[1], o_m_tlast);
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= sink_idle);
    end

    // ---- stimulus helpers ----
    function automatic void put_word(input logic [7:0] b, input logic eoa,
                                     input logic ncmd);
        t_word w;
        w.b    = b;
        w.eoa  = eoa;
        w.ncmd = ncmd;
        arg_bytes.push_back(w);
    endfunction

    // random flags; a new command follows a halt after a few ignored words
    function automatic void add_word(input logic [7:0] b);
        logic ncmd;
        ncmd = ($urandom_range(39) == 0) || (halt_left == 1);
        if (halt_left == 0)
            gen_count++;
        else
            halt_left--;
        put_word(b, $urandom_range(7) == 0, ncmd);
    endfunction

    function automatic logic [7:0] esc_letter(input int unsigned k);
        case (k)
            0:       return "E";
            1:       return "a";
            2:       return "b";
            3:       return "f";
            4:       return "n";
            5:       return "r";
            6:       return "v";
            7:       return "t";
            default: return BACKSLASH;
        endcase
    endfunction

    // mostly well-formed escape sequences, the rest noise
    function automatic void fill_random(input int target);
        int pick;
        gen_count = 0;
        while (gen_count < target) begin
            pick = $urandom_range(99);
            if (pick < 28) begin
                add_word(8'($urandom_range(255)));
            end else if (pick < 52) begin
                add_word(BACKSLASH);
                add_word(esc_letter($urandom_range(8)));
            end else if (pick < 70) begin
                add_word(BACKSLASH);
                add_word(CHAR_ZERO);
                repeat ($urandom_range(3))
                    add_word(CHAR_ZERO + 8'($urandom_range(7)));
            end else if (pick < 80) begin
                add_word(BACKSLASH);
                add_word(8'($urandom_range(255)));
            end else if (pick < 86) begin
                add_word(BACKSLASH);
                add_word(CHAR_C);
                halt_left = $urandom_range(1, 4);
            end else begin
                put_word(8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
                gen_count++;
            end
        end
    endfunction

    // wait until all words are in and all outputs are back
    task automatic settle();
        do @(negedge i_clk);
        while (arg_bytes.size() != 0 || i_s_tvalid || pending_out.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // pass_through write while the decoder is idle
    task automatic set_raw(input logic v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        raw_mode = v;
        @(negedge i_clk);
    endtask

    // ---- test sequence ----
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle  = 31;
        sink_idle = 56;
        set_raw(1'b0);

        // directed: escapes, byte extremes, octal forms, unknown escape,
        // trailing backslash, halt, ignored word, new command
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word("n", 1'b0, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word(8'h00, 1'b0, 1'b0);
        put_word(8'hFF, 1'b1, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word("E", 1'b0, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word(CHAR_ZERO, 1'b0, 1'b0);
        put_word("3", 1'b0, 1'b0);
        put_word("7", 1'b0, 1'b0);
        put_word("7", 1'b0, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word(CHAR_ZERO, 1'b1, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word("q", 1'b0, 1'b0);
        put_word(BACKSLASH, 1'b1, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word(CHAR_ZERO, 1'b0, 1'b0);
        put_word("5", 1'b0, 1'b0);
        put_word("z", 1'b0, 1'b0);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word(CHAR_C, 1'b0, 1'b0);
        put_word("x", 1'b0, 1'b0);
        put_word("y", 1'b0, 1'b1);
        settle();

        // raw mode copies escapes untouched
        set_raw(1'b1);
        put_word(BACKSLASH, 1'b0, 1'b0);
        put_word(CHAR_C, 1'b0, 1'b0);
        put_word(BACKSLASH, 1'b1, 1'b0);
        settle();

        // random phases: three idle patterns, both modes each
        for (int s = 0; s < 3; s++) begin
            src_idle  = (s == 0) ? 31 : (s == 1) ? 56 : 0;
            sink_idle = (s == 0) ? 56 : (s == 1) ? 31 : 0;
            for (int p = 0; p < 2; p++) begin
                set_raw((s == 2) ? (p == 0) : (p == 1));
                fill_random(raw_mode ? 130 : 450);
                settle();
            end
        end

        $display("Covered %0d input words (%0d in raw mode), %0d output words checked,",
                 n_in, n_raw, n_out);
        $display("%0d of them status-only, over three idle patterns.", n_status);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
